@@ hw/rtl/quoted_word_tokenizer_top_defines.svh @@
// ---------------------------------------------------------------------------
// Quoted word tokenizer assertion macros
// Shared assertion forms for the checker of the tokenizer streams.
// ---------------------------------------------------------------------------
`ifndef QUOTED_WORD_TOKENIZER_TOP_DEFINES_SVH
`define QUOTED_WORD_TOKENIZER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define QWT_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define QWT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/qwt_pkg.sv @@
// ---------------------------------------------------------------------------
// Quoted word tokenizer package
// Character codes, result codes and result types shared by the tokenizer.
// ---------------------------------------------------------------------------
package qwt_pkg;

    localparam logic [7:0] CHAR_SEMI   = 8'h3B;
    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_SQUOTE = 8'h27;
    localparam logic [7:0] CHAR_DQUOTE = 8'h22;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_CR     = 8'h0D;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [1:0] STOP_WS   = 2'd0;
    localparam logic [1:0] STOP_SEMI = 2'd1;
    localparam logic [1:0] STOP_EOT  = 2'd2;

    localparam int QueueDepth = 4;
    localparam int QueuePtrW  = $clog2(QueueDepth);
    localparam int QueueCntW  = $clog2(QueueDepth + 1);

    typedef struct packed {
        logic [7:0] out_byte;
        logic       kind;
        logic [1:0] stop_reason;
        logic       last;
    } res_t;

    typedef struct packed {
        logic [1:0] count;
        res_t       res0;
        res_t       res1;
    } res_pair_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

    function automatic res_t data_res(input logic [7:0] c);
        res_t r;
        r.out_byte    = c;
        r.kind        = KIND_DATA;
        r.stop_reason = STOP_WS;
        r.last        = 1'b0;
        return r;
    endfunction

    function automatic res_t end_res(input logic [1:0] why);
        res_t r;
        r.out_byte    = 8'h00;
        r.kind        = KIND_END;
        r.stop_reason = why;
        r.last        = 1'b1;
        return r;
    endfunction

endpackage

@@ hw/rtl/qwt_lexer.sv @@
// ---------------------------------------------------------------------------
// Quoted word tokenizer lexer
// Holds the quoting state and turns one text byte into up to two results.
// ---------------------------------------------------------------------------
module qwt_lexer (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              item_en,
    input  logic [7:0]        char_byte,
    input  logic              first_of_text,
    input  logic              end_of_text,
    output qwt_pkg::res_pair_t pair
);
    import qwt_pkg::*;

    logic skip_reg, sq_reg, dq_reg, esc_reg, fin_reg;
    logic skip_next, sq_next, dq_next, esc_next, fin_next;
    logic skip_cur, sq_cur, dq_cur, esc_cur, fin_cur;
    logic keep_bs;
    logic ws;

    always_comb begin
        skip_cur = first_of_text ? 1'b1 : skip_reg;
        sq_cur   = first_of_text ? 1'b0 : sq_reg;
        dq_cur   = first_of_text ? 1'b0 : dq_reg;
        esc_cur  = first_of_text ? 1'b0 : esc_reg;
        fin_cur  = first_of_text ? 1'b0 : fin_reg;
        ws       = is_ws(char_byte);

        skip_next = skip_cur;
        sq_next   = sq_cur;
        dq_next   = dq_cur;
        esc_next  = esc_cur;
        fin_next  = fin_cur;
        keep_bs   = 1'b0;

        pair.count = 2'd0;
        pair.res0  = data_res(char_byte);
        pair.res1  = data_res(char_byte);

        if (fin_cur) begin
            pair.count = 2'd0;
        end else if (end_of_text) begin
            pair.count = 2'd1;
            pair.res0  = end_res(STOP_EOT);
            fin_next   = 1'b1;
            esc_next   = 1'b0;
            skip_next  = 1'b0;
        end else if (skip_cur && ws) begin
            pair.count = 2'd0;
        end else begin
            skip_next = 1'b0;
            if (esc_cur) begin
                if (sq_cur) begin
                    keep_bs = (char_byte != CHAR_BSLASH) && (char_byte != CHAR_SQUOTE);
                end else if (dq_cur) begin
                    keep_bs = (char_byte != CHAR_BSLASH) && (char_byte != CHAR_DQUOTE);
                end else begin
                    keep_bs = (char_byte != CHAR_BSLASH) && (char_byte != CHAR_SQUOTE)
                              && (char_byte != CHAR_DQUOTE) && !ws;
                end
                esc_next = 1'b0;
                if (keep_bs) begin
                    pair.count     = 2'd2;
                    pair.res0      = data_res(CHAR_BSLASH);
                    pair.res1.last = 1'b1;
                end else begin
                    pair.count     = 2'd1;
                    pair.res0.last = 1'b1;
                end
            end else if (char_byte == CHAR_BSLASH) begin
                esc_next = 1'b1;
            end else if (sq_cur) begin
                if (char_byte == CHAR_SQUOTE) begin
                    sq_next = 1'b0;
                end else begin
                    pair.count     = 2'd1;
                    pair.res0.last = 1'b1;
                end
            end else if (dq_cur) begin
                if (char_byte == CHAR_DQUOTE) begin
                    dq_next = 1'b0;
                end else begin
                    pair.count     = 2'd1;
                    pair.res0.last = 1'b1;
                end
            end else if (char_byte == CHAR_SQUOTE) begin
                sq_next = 1'b1;
            end else if (char_byte == CHAR_DQUOTE) begin
                dq_next = 1'b1;
            end else if (ws) begin
                pair.count = 2'd1;
                pair.res0  = end_res(STOP_WS);
                fin_next   = 1'b1;
            end else if (char_byte == CHAR_SEMI) begin
                pair.count = 2'd1;
                pair.res0  = end_res(STOP_SEMI);
                fin_next   = 1'b1;
            end else begin
                pair.count     = 2'd1;
                pair.res0.last = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skip_reg <= 1'b1;
            sq_reg   <= 1'b0;
            dq_reg   <= 1'b0;
            esc_reg  <= 1'b0;
            fin_reg  <= 1'b0;
        end else if (item_en) begin
            skip_reg <= skip_next;
            sq_reg   <= sq_next;
            dq_reg   <= dq_next;
            esc_reg  <= esc_next;
            fin_reg  <= fin_next;
        end
    end

endmodule

@@ hw/rtl/qwt_res_queue.sv @@
// ---------------------------------------------------------------------------
// Quoted word tokenizer result queue
// Takes up to two results per cycle and delivers them one per transfer.
// ---------------------------------------------------------------------------
module qwt_res_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_en,
    input  qwt_pkg::res_pair_t push_pair,
    output logic               room,
    output logic               out_valid,
    input  logic               out_ready,
    output qwt_pkg::res_t      out_res
);
    import qwt_pkg::*;

    res_t                 mem [QueueDepth];
    logic [QueuePtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QueuePtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QueueCntW-1:0] count_reg, count_next;
    logic [1:0]           push_n;
    logic                 pop;

    assign push_n    = push_en ? push_pair.count : 2'd0;
    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign out_res   = mem[rd_ptr_reg];
    assign room      = (count_reg <= QueueCntW'(QueueDepth - 2));

    always_comb begin
        wr_ptr_next = wr_ptr_reg + QueuePtrW'(push_n);
        rd_ptr_next = rd_ptr_reg + QueuePtrW'(pop);
        count_next  = count_reg + QueueCntW'(push_n) - QueueCntW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            mem[wr_ptr_reg] <= push_pair.res0;
        end
        if (push_n == 2'd2) begin
            mem[wr_ptr_reg + QueuePtrW'(1)] <= push_pair.res1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ hw/rtl/quoted_word_tokenizer_top.sv @@
// ---------------------------------------------------------------------------
// Quoted word tokenizer top level
// Extracts one shell-style quoted word from a byte stream.
// ---------------------------------------------------------------------------
// Each input transfer is first held in the input register; its results are then
// written into the result queue, from which they are offered.
// Throughput: one input transfer per cycle; an escaped byte that keeps its
// backslash yields two results, which leave one after the other through the
// four-entry result queue. The input stalls only while the queue holds three
// or more results. Reset clears the parser state and empties the queue.
module quoted_word_tokenizer_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_byte
    input  logic [0:0]  s_tuser,   // [0] first_of_text
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [9:8] stop_reason, rest zero
    output logic [0:0]  m_tuser,   // [0] kind
    output logic        m_tlast    // last
);
    import qwt_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] char_reg;
    logic       first_reg;
    logic       eot_reg;
    logic       s_xfer;
    logic       advance;
    logic       room;
    res_pair_t  pair;
    res_t       out_res;

    assign s_xfer   = s_tvalid && s_tready;
    assign advance  = in_valid_reg && room;
    assign s_tready = !in_valid_reg || room;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_xfer) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            char_reg  <= s_tdata;
            first_reg <= s_tuser[0];
            eot_reg   <= s_tlast;
        end
    end

    qwt_lexer u_lexer (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .item_en       (advance),
        .char_byte     (char_reg),
        .first_of_text (first_reg),
        .end_of_text   (eot_reg),
        .pair          (pair)
    );

    qwt_res_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_en   (advance),
        .push_pair (pair),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {6'b0, out_res.stop_reason, out_res.out_byte};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last;

endmodule

@@ hw/rtl/qwt_checker.sv @@
// ---------------------------------------------------------------------------
// Quoted word tokenizer checker
// Watches the result stream of the tokenizer top level.
// ---------------------------------------------------------------------------
`include "quoted_word_tokenizer_top_defines.svh"

module qwt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [0:0]  m_tuser,
    input logic        m_tlast
);
    import qwt_pkg::*;

    `QWT_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "Result changed while stalled.")
    `QWT_ASSERT_NOW(a_end_last, aclk, aresetn, m_tvalid && (m_tuser[0] == KIND_END), m_tlast && (m_tdata[7:0] == 8'h00), "Word end is not a clean final result.")
    `QWT_ASSERT_NOW(a_data_reason, aclk, aresetn, m_tvalid && (m_tuser[0] == KIND_DATA), m_tdata[9:8] == STOP_WS, "Data byte carries a stop reason.")
    `QWT_ASSERT_NOW(a_reason_range, aclk, aresetn, m_tvalid, (m_tdata[9:8] != 2'd3) && (m_tdata[15:10] == 6'b0), "Result padding or reason out of range.")

endmodule

bind quoted_word_tokenizer_top qwt_checker u_qwt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
